>>> hdl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and constants shared by the sliding-window sender core.
// ----------------------------------------------------------------------------
package rsw_pkg;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned AGE_W   = 24;
  localparam int unsigned WIN_W   = 6;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEQ_W-1:0] SEQ_MOD = 16'hFFFF;
  localparam logic [AGE_W-1:0] AGE_MAX = 24'hFFFFFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Input functions.
  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_ACK    = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_IDLE     = 3'd0;
  localparam logic [2:0] KIND_TRANSMIT = 3'd1;
  localparam logic [2:0] KIND_PENDING  = 3'd2;
  localparam logic [2:0] KIND_REJECTED = 3'd3;
  localparam logic [2:0] KIND_CLOSED   = 3'd4;

  // Entry states.
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_SENT    = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [SEQ_W-1:0] buffer_handle;
    logic [SEQ_W-1:0] ack_number;
    logic             ack_failed;
    logic [SEQ_W-1:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SEQ_W-1:0] seq_number;
    logic [SEQ_W-1:0] handle_out;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUBMIT,
    OP_ACK,
    OP_CLEAR,
    OP_POP,
    OP_SEND,
    OP_TICK,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } rsw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       ack_hit;
    logic       ack_failed;
    logic       walk_end;
    logic       cur_done;
    logic       win_reached;
    logic       tick_expire;
    logic       popped;
  } rsw_stat_t;

endpackage

>>> hdl/rsw_ctrl.sv
// ----------------------------------------------------------------------------
// rsw_ctrl
// Sequencer that steps the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module rsw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rsw_pkg::rsw_stat_t stat,
  output rsw_pkg::rsw_cmd_t  cmd,
  output logic               busy
);
  import rsw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RETIRE,
    S_SEND,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          FUNC_SUBMIT: begin
            cmd.op    = OP_SUBMIT;
            state_nxt = S_FLUSH;
          end
          FUNC_ACK: begin
            if (stat.ack_hit) begin
              cmd.op    = OP_ACK;
              state_nxt = stat.ack_failed ? S_FLUSH : S_RETIRE;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
          FUNC_TICK: state_nxt = S_TICK;
          default: begin
            cmd.op    = OP_CLEAR;
            state_nxt = S_FLUSH;
          end
        endcase
      end
      S_RETIRE: begin
        if (!stat.walk_end && stat.cur_done) begin
          cmd.op = OP_POP;
        end else begin
          state_nxt = stat.popped ? S_SEND : S_FLUSH;
        end
      end
      S_SEND: begin
        if (stat.walk_end || stat.win_reached) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.op = OP_SEND;
        end
      end
      S_TICK: begin
        if (stat.walk_end) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.op = OP_TICK;
          if (stat.tick_expire) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.op    = OP_FLUSH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hdl/rsw_dp.sv
// ----------------------------------------------------------------------------
// rsw_dp
// Queue storage, pointers, ageing arithmetic and the result register.
// ----------------------------------------------------------------------------
module rsw_dp #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsw_pkg::rsw_cmd_t               cmd,
  output rsw_pkg::rsw_stat_t              stat,
  input  rsw_pkg::in_item_t               in_item,
  input  logic                            cfg_we,
  input  logic [rsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsw_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  output rsw_pkg::out_item_t              out_item
);
  import rsw_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (SUM_W > WIN_W) ? SUM_W : WIN_W;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // Entry storage, undefined until written.
  logic [1:0]       status_r [QUEUE_DEPTH];
  logic [SEQ_W-1:0] handle_r [QUEUE_DEPTH];
  logic [AGE_W-1:0] tage_r   [QUEUE_DEPTH];
  logic [AGE_W-1:0] rage_r   [QUEUE_DEPTH];

  logic [WIN_W-1:0] win_r, win_nxt;
  logic [AGE_W-1:0] resend_r, resend_nxt;
  logic [AGE_W-1:0] timeout_r, timeout_nxt;

  logic [PTR_W-1:0] head_ptr_r, head_ptr_nxt;
  logic [SEQ_W-1:0] head_seq_r, head_seq_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [WIN_W-1:0] sent_r, sent_nxt;
  logic             popped_r, popped_nxt;
  logic             hit_r, hit_nxt;
  in_item_t         item_r, item_nxt;

  logic             hold_valid_r, hold_valid_nxt;
  out_item_t        hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SEQ_W:0] s;
    s = {1'b0, base} + (SEQ_W+1)'(off);
    if (s >= {1'b0, SEQ_MOD}) s = s - {1'b0, SEQ_MOD};
    return s[SEQ_W-1:0];
  endfunction

  function automatic logic [AGE_W-1:0] age_add(input logic [AGE_W-1:0] a,
                                               input logic [SEQ_W-1:0] d);
    logic [AGE_W:0] s;
    s = {1'b0, a} + (AGE_W+1)'(d);
    return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
  endfunction

  logic [PTR_W-1:0] rd_slot, tail_slot;
  logic [1:0]       cur_st;
  logic [SEQ_W-1:0] cur_seq, tail_seq;
  logic [WIN_W-1:0] win_eff;
  logic [AGE_W-1:0] rsd_eff, tmo_eff;
  logic [AGE_W-1:0] tage_sum, rage_sum;
  logic             tick_expire;
  logic [SEQ_W:0]   ack_diff;
  logic [SEQ_W-1:0] ack_off;

  assign rd_slot   = slot_of(head_ptr_r, idx_r);
  assign tail_slot = slot_of(head_ptr_r, count_r);
  assign cur_st    = status_r[rd_slot];
  assign cur_seq   = seq_add(head_seq_r, idx_r);
  assign tail_seq  = seq_add(head_seq_r, count_r);
  assign win_eff   = (win_r == '0) ? WIN_W'(1) : win_r;
  assign rsd_eff   = (resend_r == '0) ? AGE_W'(1) : resend_r;
  assign tmo_eff   = (timeout_r == '0) ? AGE_W'(1) : timeout_r;
  assign tage_sum  = age_add(tage_r[rd_slot], item_r.elapsed_ticks);
  assign rage_sum  = age_add(rage_r[rd_slot], item_r.elapsed_ticks);
  assign tick_expire = (cur_st == ST_SENT) && (tage_sum > tmo_eff);

  // Offset of the acked number from the head, modulo the sequence space.
  always_comb begin
    if (in_item.ack_number >= head_seq_r) begin
      ack_diff = {1'b0, in_item.ack_number} - {1'b0, head_seq_r};
    end else begin
      ack_diff = {1'b0, in_item.ack_number} + {1'b0, SEQ_MOD} - {1'b0, head_seq_r};
    end
    ack_off = ack_diff[SEQ_W-1:0];
  end

  assign stat.func        = item_r.func;
  assign stat.ack_hit     = hit_r;
  assign stat.ack_failed  = item_r.ack_failed;
  assign stat.walk_end    = (idx_r >= count_r);
  assign stat.cur_done    = (cur_st == ST_DONE);
  assign stat.win_reached = (sent_r == win_eff);
  assign stat.tick_expire = tick_expire;
  assign stat.popped      = popped_r;

  // Entry write port.
  logic             we_st, we_hd, we_ta, we_ra;
  logic [PTR_W-1:0] wa;
  logic [1:0]       wd_st;
  logic [AGE_W-1:0] wd_ta, wd_ra;

  // New result from this cycle.
  logic             emit;
  out_item_t        emit_item;

  always_comb begin
    win_nxt        = win_r;
    resend_nxt     = resend_r;
    timeout_nxt    = timeout_r;
    head_ptr_nxt   = head_ptr_r;
    head_seq_nxt   = head_seq_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    sent_nxt       = sent_r;
    popped_nxt     = popped_r;
    hit_nxt        = hit_r;
    item_nxt       = item_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    we_st = 1'b0;
    we_hd = 1'b0;
    we_ta = 1'b0;
    we_ra = 1'b0;
    wa    = rd_slot;
    wd_st = ST_SENT;
    wd_ta = '0;
    wd_ra = '0;
    emit  = 1'b0;
    emit_item.kind       = KIND_TRANSMIT;
    emit_item.seq_number = cur_seq;
    emit_item.handle_out = handle_r[rd_slot];
    emit_item.last       = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW:  win_nxt     = cfg_data[WIN_W-1:0];
        CFG_RESEND:  resend_nxt  = cfg_data[AGE_W-1:0];
        CFG_TIMEOUT: timeout_nxt = cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        item_nxt       = in_item;
        hit_nxt        = (in_item.ack_number != SEQ_MOD) &&
                         (ack_off < SEQ_W'(count_r));
        idx_nxt        = (in_item.func == FUNC_ACK) ? ack_off[CNT_W-1:0] : '0;
        sent_nxt       = '0;
        popped_nxt     = 1'b0;
        hold_valid_nxt = 1'b0;
      end
      OP_SUBMIT: begin
        emit                 = 1'b1;
        emit_item.seq_number = tail_seq;
        emit_item.handle_out = item_r.buffer_handle;
        if (count_r >= DEPTH_C) begin
          emit_item.kind = KIND_REJECTED;
        end else begin
          we_st = 1'b1;
          we_hd = 1'b1;
          we_ta = 1'b1;
          we_ra = 1'b1;
          wa    = tail_slot;
          count_nxt = count_r + CNT_W'(1);
          if ((CMP_W'(count_r) + CMP_W'(1)) <= CMP_W'(win_eff)) begin
            wd_st          = ST_SENT;
            emit_item.kind = KIND_TRANSMIT;
          end else begin
            wd_st          = ST_PENDING;
            emit_item.kind = KIND_PENDING;
          end
        end
      end
      OP_ACK: begin
        if (item_r.ack_failed) begin
          we_ra = 1'b1;
          emit  = 1'b1;
        end else begin
          we_st = 1'b1;
          wd_st = ST_DONE;
        end
        idx_nxt = '0;
      end
      OP_CLEAR: begin
        count_nxt    = '0;
        head_seq_nxt = '0;
      end
      OP_POP: begin
        head_ptr_nxt = slot_of(head_ptr_r, CNT_W'(1));
        head_seq_nxt = seq_add(head_seq_r, CNT_W'(1));
        count_nxt    = count_r - CNT_W'(1);
        popped_nxt   = 1'b1;
      end
      OP_SEND: begin
        if (cur_st == ST_PENDING) begin
          we_st    = 1'b1;
          we_ta    = 1'b1;
          we_ra    = 1'b1;
          emit     = 1'b1;
          sent_nxt = sent_r + WIN_W'(1);
        end
        idx_nxt = idx_r + CNT_W'(1);
      end
      OP_TICK: begin
        if (cur_st == ST_SENT) begin
          if (tick_expire) begin
            emit           = 1'b1;
            emit_item.kind = KIND_CLOSED;
            count_nxt      = '0;
            head_seq_nxt   = '0;
          end else begin
            we_ta = 1'b1;
            wd_ta = tage_sum;
            we_ra = 1'b1;
            if (rage_sum > rsd_eff) begin
              wd_ra = '0;
              emit  = 1'b1;
            end else begin
              wd_ra = rage_sum;
            end
          end
        end
        idx_nxt = idx_r + CNT_W'(1);
      end
      OP_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (hold_valid_r) begin
          out_item_nxt = hold_r;
        end else begin
          out_item_nxt.kind       = KIND_IDLE;
          out_item_nxt.seq_number = '0;
          out_item_nxt.handle_out = '0;
        end
        out_item_nxt.last = 1'b1;
        hold_valid_nxt    = 1'b0;
      end
      default: ;
    endcase

    // A new result pushes the held one out; the final one leaves on flush.
    if (emit) begin
      if (hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = hold_r;
      end
      hold_nxt       = emit_item;
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_st) status_r[wa] <= wd_st;
    if (we_hd) handle_r[wa] <= item_r.buffer_handle;
    if (we_ta) tage_r[wa]   <= wd_ta;
    if (we_ra) rage_r[wa]   <= wd_ra;
    item_r     <= item_nxt;
    hold_r     <= hold_nxt;
    out_item_r <= out_item_nxt;
    idx_r      <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= WIN_W'(10);
      resend_r     <= AGE_W'(500);
      timeout_r    <= AGE_W'(3000);
      head_ptr_r   <= '0;
      head_seq_r   <= '0;
      count_r      <= '0;
      sent_r       <= '0;
      popped_r     <= 1'b0;
      hit_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      resend_r     <= resend_nxt;
      timeout_r    <= timeout_nxt;
      head_ptr_r   <= head_ptr_nxt;
      head_seq_r   <= head_seq_nxt;
      count_r      <= count_nxt;
      sent_r       <= sent_nxt;
      popped_r     <= popped_nxt;
      hit_r        <= hit_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hdl/reliable_send_window_core.sv
// ----------------------------------------------------------------------------
// reliable_send_window_core
// Sender side of a selective-repeat sliding window: queue, acks and ageing.
// ----------------------------------------------------------------------------
// Steps: a submit, clear, failed ack or ack for an unknown number passes
// through dispatch and flush only. A tick walks the queue, one entry a cycle,
// until the end or the first timeout. A successful ack retires done entries
// and, if any retired, then walks the rest for pending ones.
// Throughput: one transaction at a time, set by the single-entry walk over the
// queue storage. Results come one a cycle at most and cannot be stalled.
// Reset (synchronous, active low) empties the queue and loads the default
// window, resend and timeout registers; no clearing pass is needed.
module reliable_send_window_core #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rsw_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output rsw_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [rsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsw_pkg::CFG_W-1:0]       cfg_data
);
  import rsw_pkg::*;

  rsw_cmd_t  cmd;
  rsw_stat_t stat;

  // The controller decides which step runs each cycle; the datapath only
  // carries it out and reports the conditions the controller branches on.
  rsw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The queue is a ring: the head slot moves as entries retire, so no data
  // is ever shifted. Each transaction's results pass through a one-deep hold
  // register so that the final one can be flagged as last.
  rsw_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
